// File: sv/can_taxel_frame_demux_top_defines.svh
// Assertion macros for the tactile frame demultiplexer checker.
`ifndef CAN_TAXEL_FRAME_DEMUX_TOP_DEFINES_SVH
`define CAN_TAXEL_FRAME_DEMUX_TOP_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define CTFD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define CTFD_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// File: sv/ctfd_pkg.sv
// Shared types and constants of the tactile frame demultiplexer.
`default_nettype none
package ctfd_pkg;

	localparam int unsigned TRIANGLES = 16;
	localparam int unsigned SLOTS     = 12;
	localparam int unsigned LO_SLOTS  = 7;

	localparam logic [2:0]  ID_CLASS_TAXEL = 3'd3;
	localparam logic [10:0] ID_DEBUG       = 11'h100;
	localparam logic [3:0]  CARD_FIRST     = 4'd14;
	localparam logic [3:0]  CARD_LAST      = 4'd8;
	localparam logic [7:0]  READING_FILL   = 8'hFF;
	localparam logic [16:0] RECIP3         = 17'd171;

	typedef enum logic [2:0] {
		ST_STORED  = 3'd0,
		ST_DEBUG   = 3'd1,
		ST_ABORT   = 3'd2,
		ST_IGNORED = 3'd3,
		ST_SKIPPED = 3'd4,
		ST_READ    = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		OP_NONE      = 3'd0,
		OP_WR_LO     = 3'd1,
		OP_WR_HI     = 3'd2,
		OP_READ      = 3'd3,
		OP_READ_ZERO = 3'd4
	} op_t;

	// Classified work item handed from front to back (row index travels beside it)
	typedef struct packed {
		op_t         op;
		status_t     status;
		logic        batch_ok;
		logic [3:0]  slot;
		logic [55:0] data;
	} ctfd_cmd_t;

endpackage
`default_nettype wire

// File: sv/can_taxel_frame_demux_top.sv
// Top level of the tactile frame demultiplexer.
//
//  port group                          | dir | transfer
//  start/busy + cmd..read_index        | in  | start & !busy at clock edge
//  done + status, reading, batch_ok    | out | done high one cycle
//
// One item per cycle while busy is low. A result shows on done once its transfer
// has passed the queue, back-end stage 1 (store read/write) and the result register.
// busy is high only while the two-entry queue is full; the back end drains it
// every cycle, since the receiver cannot stall.
// Reset clears half-row written flags so the store reads 255; no clearing pass.
`default_nettype none
module can_taxel_frame_demux_top
	import ctfd_pkg::*;
#(
	parameter int unsigned CARDS = 7
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        cmd,
	input  wire logic [10:0] frame_id,
	input  wire logic [63:0] payload,
	input  wire logic        batch_last,
	input  wire logic [10:0] read_index,
	output logic             done,
	output logic      [2:0]  status,
	output logic      [7:0]  reading,
	output logic             batch_ok
);

	localparam int unsigned ROWS  = CARDS * TRIANGLES;
	localparam int unsigned ROW_W = $clog2(ROWS);
	localparam int unsigned Q_W   = $bits(ctfd_cmd_t) + ROW_W;

	logic             accept;
	ctfd_cmd_t        f_item, b_item;
	logic [ROW_W-1:0] f_row, b_row;
	logic             q_full, q_empty;
	logic [Q_W-1:0]   q_rdata;

	assign accept = start && !q_full;
	assign busy   = q_full;

	ctfd_front #(.CARDS(CARDS), .ROW_W(ROW_W)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.cmd        (cmd),
		.frame_id   (frame_id),
		.payload    (payload),
		.batch_last (batch_last),
		.read_index (read_index),
		.item       (f_item),
		.row        (f_row)
	);

	ctfd_queue #(.WIDTH(Q_W)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (accept),
		.wdata  ({f_item, f_row}),
		.pop    (!q_empty),
		.full   (q_full),
		.empty  (q_empty),
		.rdata  (q_rdata)
	);

	assign b_item = q_rdata[Q_W-1:ROW_W];
	assign b_row  = q_rdata[ROW_W-1:0];

	ctfd_back #(.ROWS(ROWS), .ROW_W(ROW_W)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (!q_empty),
		.item     (b_item),
		.row      (b_row),
		.done     (done),
		.status   (status),
		.reading  (reading),
		.batch_ok (batch_ok)
	);

endmodule
`default_nettype wire

// File: sv/ctfd_front.sv
// Front end: classifies frames and reads, tracks the batch state.
`default_nettype none
module ctfd_front
	import ctfd_pkg::*;
#(
	parameter int unsigned CARDS = 7,
	parameter int unsigned ROW_W = 7
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              accept,
	input  wire logic              cmd,
	input  wire logic [10:0]       frame_id,
	input  wire logic [63:0]       payload,
	input  wire logic              batch_last,
	input  wire logic [10:0]       read_index,
	output ctfd_cmd_t              item,
	output logic      [ROW_W-1:0]  row
);

	localparam int unsigned DEPTH = CARDS * TRIANGLES * SLOTS;

	logic        ended_q, failed_q;
	logic        ended_d, failed_d;
	logic        ended_step, failed_step;
	logic [3:0]  card, board;
	logic        card_ok;
	logic [16:0] prod;
	logic [7:0]  quot;
	logic [8:0]  rem3;
	logic [3:0]  read_slot;
	logic        in_range;

	// Decode card code into board number
	assign card    = frame_id[7:4];
	assign board   = CARD_FIRST - card;
	assign card_ok = (card >= CARD_LAST) && (card <= CARD_FIRST) && (board < 4'(CARDS));

	// Split read index into row and slot: index / 12 = (index / 4) / 3
	assign prod      = 17'(read_index[10:2]) * RECIP3;
	assign quot      = prod[16:9];
	assign rem3      = read_index[10:2] - (9'({quot, 1'b0}) + 9'(quot));
	assign read_slot = {rem3[1:0], read_index[1:0]};
	assign in_range  = read_index < 11'(DEPTH);

	// Classify the item
	always_comb begin
		item.op       = OP_NONE;
		item.status   = ST_IGNORED;
		item.slot     = '0;
		item.data     = payload[63:8];
		row           = '0;
		ended_step    = ended_q;
		failed_step   = failed_q;
		if (cmd) begin
			item.op     = in_range ? OP_READ : OP_READ_ZERO;
			item.status = ST_READ;
			item.slot   = read_slot;
			row         = ROW_W'(quot);
		end else if (ended_q) begin
			item.status = ST_SKIPPED;
		end else if (frame_id[10:8] == ID_CLASS_TAXEL) begin
			if (card_ok) begin
				item.op     = payload[7] ? OP_WR_HI : OP_WR_LO;
				item.status = ST_STORED;
				row         = ROW_W'({board[2:0], frame_id[3:0]});
			end else begin
				item.status = ST_ABORT;
				ended_step  = 1'b1;
				failed_step = 1'b1;
			end
		end else if (frame_id == ID_DEBUG) begin
			item.status = ST_DEBUG;
			ended_step  = 1'b1;
		end
		item.batch_ok = !failed_step;
	end

	// Drop batch state after the last frame of a batch
	always_comb begin
		ended_d  = ended_step;
		failed_d = failed_step;
		if (!cmd && batch_last) begin
			ended_d  = 1'b0;
			failed_d = 1'b0;
		end
	end

	// Hold batch state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ended_q  <= 1'b0;
			failed_q <= 1'b0;
		end else if (accept) begin
			ended_q  <= ended_d;
			failed_q <= failed_d;
		end
	end

endmodule
`default_nettype wire

// File: sv/ctfd_queue.sv
// Two-entry queue between the front and back ends.
`default_nettype none
module ctfd_queue
	import ctfd_pkg::*;
#(
	parameter int unsigned WIDTH = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             pop,
	output logic                  full,
	output logic                  empty,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] entry_q [2];
	logic             wr_ptr_q, rd_ptr_q;
	logic [1:0]       cnt_q;

	assign full  = cnt_q == 2'd2;
	assign empty = cnt_q == 2'd0;
	assign rdata = entry_q[rd_ptr_q];

	// Store entries
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wdata;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule
`default_nettype wire

// File: sv/ctfd_back.sv
// Back end: reading store, half-row writes and reads, result register.
`default_nettype none
module ctfd_back
	import ctfd_pkg::*;
#(
	parameter int unsigned ROWS  = 112,
	parameter int unsigned ROW_W = 7
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             go,
	input  wire ctfd_cmd_t        item,
	input  wire logic [ROW_W-1:0] row,
	output logic                  done,
	output logic      [2:0]       status,
	output logic      [7:0]       reading,
	output logic                  batch_ok
);

	// Slots 0..6 and 7..11 of each row are always written whole
	logic [55:0] lo_mem_q [ROWS];
	logic [39:0] hi_mem_q [ROWS];
	logic [ROWS-1:0] lo_vld_q, hi_vld_q;

	logic        vld_s1;
	op_t         op_s1;
	status_t     status_s1;
	logic        ok_s1;
	logic [3:0]  slot_s1;
	logic [55:0] lo_rd_s1;
	logic [39:0] hi_rd_s1;
	logic        lo_vld_s1, hi_vld_s1;

	logic [2:0]  hi_sel;
	logic [7:0]  rd_byte;

	logic        done_q;
	status_t     status_q;
	logic [7:0]  reading_q;
	logic        ok_q;

	// Write and read the memories
	always_ff @(posedge clk) begin
		if (go && item.op == OP_WR_LO) begin
			lo_mem_q[row] <= item.data;
		end
		if (go && item.op == OP_WR_HI) begin
			hi_mem_q[row] <= item.data[39:0];
		end
		lo_rd_s1 <= lo_mem_q[row];
		hi_rd_s1 <= hi_mem_q[row];
	end

	// Mark half-rows written since reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_vld_q <= '0;
			hi_vld_q <= '0;
		end else if (go) begin
			if (item.op == OP_WR_LO) begin
				lo_vld_q[row] <= 1'b1;
			end
			if (item.op == OP_WR_HI) begin
				hi_vld_q[row] <= 1'b1;
			end
		end
	end

	// Stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= go;
		end
	end

	always_ff @(posedge clk) begin
		op_s1     <= item.op;
		status_s1 <= item.status;
		ok_s1     <= item.batch_ok;
		slot_s1   <= item.slot;
		lo_vld_s1 <= lo_vld_q[row];
		hi_vld_s1 <= hi_vld_q[row];
	end

	// Select the addressed byte; unwritten half-rows read as the fill value
	assign hi_sel = 3'(slot_s1 - 4'(LO_SLOTS));
	always_comb begin
		if (slot_s1 < 4'(LO_SLOTS)) begin
			rd_byte = lo_vld_s1 ? 8'(lo_rd_s1 >> {slot_s1[2:0], 3'b000}) : READING_FILL;
		end else begin
			rd_byte = hi_vld_s1 ? 8'(hi_rd_s1 >> {hi_sel, 3'b000}) : READING_FILL;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		status_q  <= status_s1;
		reading_q <= (op_s1 == OP_READ) ? rd_byte : 8'd0;
		ok_q      <= ok_s1;
	end

	assign done     = done_q;
	assign status   = status_q;
	assign reading  = reading_q;
	assign batch_ok = ok_q;

endmodule
`default_nettype wire

// File: sv/ctfd_checker.sv
// Port-level checker for the tactile frame demultiplexer, bound to the top level.
`default_nettype none
`include "can_taxel_frame_demux_top_defines.svh"
module ctfd_checker
	import ctfd_pkg::*;
(
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       start,
	input wire logic       busy,
	input wire logic       done,
	input wire logic [2:0] status,
	input wire logic [7:0] reading,
	input wire logic       batch_ok
);

	// Every transfer yields its result on done after the queue, stage 1 and the result register
	`CTFD_ASSERT(a_latency, (start && !busy) |-> ##3 done, "result missing after transfer")
	// Only reads carry a reading
	`CTFD_ASSERT(a_reading_zero, (done && status != ST_READ) |-> reading == 8'd0, "reading on non-read")
	// An abort always reports a failed batch
	`CTFD_ASSERT(a_abort_fail, (done && status == ST_ABORT) |-> !batch_ok, "abort with batch ok")
	// No result appears without an earlier transfer
	`CTFD_NEVER(a_spurious, done && !$past(start && !busy, 3), "result without transfer")

endmodule

bind can_taxel_frame_demux_top ctfd_checker u_ctfd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.start    (start),
	.busy     (busy),
	.done     (done),
	.status   (status),
	.reading  (reading),
	.batch_ok (batch_ok)
);
`default_nettype wire
